@@ rtl/bdcd_pkg.sv @@
// bdcd_pkg: shared types, constants and helpers for the button debounce and combo detector
// no dependencies

package bdcd_pkg;

   localparam int TIME_BITS = 32;
   localparam int CFG_BITS  = 16;
   localparam int NUM_BTN   = 3;
   localparam int REQ_BITS  = 40;
   localparam int RSP_BITS  = 16;

   localparam int BTN_BLUE   = 0;
   localparam int BTN_RED    = 1;
   localparam int BTN_YELLOW = 2;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_COMBO    = 2'd1,
      CSR_PULSE    = 2'd2
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(30);
   localparam logic [CFG_BITS-1:0] COMBO_RESET    = CFG_BITS'(100);
   localparam logic [CFG_BITS-1:0] PULSE_RESET    = CFG_BITS'(500);

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] pair_wait_ms;
      logic [CFG_BITS-1:0] pulse_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic [NUM_BTN-1:0] raw_buttons;
      logic               link_online;
   } req_item_type;

   typedef struct packed {
      logic [NUM_BTN-1:0] stable_buttons;
      logic               relay_on;
      logic               relay_off;
      logic               yellow_event;
      logic               combo_event;
      logic               red_event;
      logic               blue_event;
   } rsp_item_type;

   // wrapping elapsed-time check
   function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
                                    input logic [TIME_BITS-1:0] since,
                                    input logic [CFG_BITS-1:0]  span);
      logic [TIME_BITS-1:0] diff;
      begin
         diff    = now - since;
         elapsed = (diff >= TIME_BITS'(span));
      end
   endfunction

endpackage

@@ rtl/bdcd_csr.sv @@
// bdcd_csr: configuration registers for debounce, combo window and pulse length
// depends on bdcd_pkg

module bdcd_csr
   import bdcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: cfg_in.debounce_ms  = csr_wdata;
            CSR_COMBO:    cfg_in.pair_wait_ms = csr_wdata;
            CSR_PULSE:    cfg_in.pulse_ms     = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_RESET;
         cfg_ff.pair_wait_ms <= COMBO_RESET;
         cfg_ff.pulse_ms     <= PULSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/bdcd_core.sv @@
// bdcd_core: debounce state, pending presses, relay pulse and the one-sample step logic
// depends on bdcd_pkg

module bdcd_core
   import bdcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic [NUM_BTN-1:0]   raw_ff, raw_in;
   logic [NUM_BTN-1:0]   stable_ff, stable_in;
   logic [TIME_BITS-1:0] change_ff [NUM_BTN];
   logic [TIME_BITS-1:0] change_in [NUM_BTN];
   logic                 seeded_ff, seeded_in;
   logic                 blue_pend_ff, blue_pend_in;
   logic                 red_pend_ff, red_pend_in;
   logic [TIME_BITS-1:0] blue_time_ff, blue_time_in;
   logic [TIME_BITS-1:0] red_time_ff, red_time_in;
   logic                 pulse_ff, pulse_in;
   logic [TIME_BITS-1:0] pulse_time_ff, pulse_time_in;

   logic [TIME_BITS-1:0] now;
   logic [NUM_BTN-1:0]   rise;
   logic                 ev_blue, ev_red, ev_combo, relay_off;

   assign now = TIME_BITS'(item.now_ms);

   always_comb begin
      raw_in        = raw_ff;
      stable_in     = stable_ff;
      change_in     = change_ff;
      seeded_in     = seeded_ff;
      blue_pend_in  = blue_pend_ff;
      red_pend_in   = red_pend_ff;
      blue_time_in  = blue_time_ff;
      red_time_in   = red_time_ff;
      pulse_in      = pulse_ff;
      pulse_time_in = pulse_time_ff;
      rise          = '0;
      ev_blue       = 1'b0;
      ev_red        = 1'b0;
      ev_combo      = 1'b0;

      relay_off = pulse_ff && elapsed(now, pulse_time_ff, cfg.pulse_ms);
      if (relay_off) begin
         pulse_in = 1'b0;
      end

      if (!item.link_online) begin
         seeded_in = 1'b0;
      end else if (!seeded_ff) begin
         raw_in    = item.raw_buttons;
         stable_in = item.raw_buttons;
         for (int i = 0; i < NUM_BTN; i++) begin
            change_in[i] = now;
         end
         seeded_in = 1'b1;
      end else begin
         for (int i = 0; i < NUM_BTN; i++) begin
            if (item.raw_buttons[i] != raw_ff[i]) begin
               raw_in[i]    = item.raw_buttons[i];
               change_in[i] = now;
            end else if (item.raw_buttons[i] != stable_ff[i] &&
                         elapsed(now, change_ff[i], cfg.debounce_ms)) begin
               stable_in[i] = item.raw_buttons[i];
               rise[i]      = item.raw_buttons[i];
            end
         end

         if (rise[BTN_BLUE]) begin
            blue_pend_in = 1'b1;
            blue_time_in = now;
         end
         if (rise[BTN_RED]) begin
            red_pend_in = 1'b1;
            red_time_in = now;
         end
         if (rise[BTN_YELLOW]) begin
            pulse_in      = 1'b1;
            pulse_time_in = now;
         end

         if (blue_pend_in && red_pend_in) begin
            ev_combo     = 1'b1;
            blue_pend_in = 1'b0;
            red_pend_in  = 1'b0;
         end else begin
            if (blue_pend_in && elapsed(now, blue_time_in, cfg.pair_wait_ms)) begin
               ev_blue      = 1'b1;
               blue_pend_in = 1'b0;
            end
            if (red_pend_in && elapsed(now, red_time_in, cfg.pair_wait_ms)) begin
               ev_red      = 1'b1;
               red_pend_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      result.blue_event     = ev_blue;
      result.red_event      = ev_red;
      result.combo_event    = ev_combo;
      result.yellow_event   = rise[BTN_YELLOW];
      result.relay_off      = relay_off;
      result.relay_on       = rise[BTN_YELLOW];
      result.stable_buttons = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff        <= '0;
         stable_ff     <= '0;
         seeded_ff     <= 1'b0;
         blue_pend_ff  <= 1'b0;
         red_pend_ff   <= 1'b0;
         blue_time_ff  <= '0;
         red_time_ff   <= '0;
         pulse_ff      <= 1'b0;
         pulse_time_ff <= '0;
         for (int i = 0; i < NUM_BTN; i++) begin
            change_ff[i] <= '0;
         end
      end else if (step) begin
         raw_ff        <= raw_in;
         stable_ff     <= stable_in;
         seeded_ff     <= seeded_in;
         blue_pend_ff  <= blue_pend_in;
         red_pend_ff   <= red_pend_in;
         blue_time_ff  <= blue_time_in;
         red_time_ff   <= red_time_in;
         pulse_ff      <= pulse_in;
         pulse_time_ff <= pulse_time_in;
         for (int i = 0; i < NUM_BTN; i++) begin
            change_ff[i] <= change_in[i];
         end
      end
   end

endmodule

@@ rtl/button_debounce_combo_detector_unit.sv @@
// button_debounce_combo_detector_unit: top level with input and result registers
// depends on bdcd_pkg, bdcd_csr, bdcd_core
//
//  port group   dir   handshake          payload
//  req_         in    tvalid / tready    tdata: link_online, raw_buttons, now_ms
//  rsp_         out   tvalid / tready    tdata: events, relay flags, stable_buttons
//  csr_         in    wr_en              index, wdata
//
// one sample per clock sustained while rsp_ is not stalled; the input transfer is registered in
// the input register and its result then in the result register
// the step logic is a single combinational pass between the two registers
// reset clears valids, debounce state and loads default settings
// a stalled rsp_ holds the result and one more sample while taking none

module button_debounce_combo_detector_unit
   import bdcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // link_online, raw_buttons[3], now_ms[32], zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,  // blue, red, combo, yellow, relay_off, relay_on,
                                           // stable_buttons[3], zero pad
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   localparam int REQ_USED = $bits(req_item_type);
   localparam int RSP_USED = $bits(rsp_item_type);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   cfg_type      cfg;
   logic         step;

   bdcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdcd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item_type'(req_tdata[REQ_USED-1:0]);
      end
      if (step) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS-RSP_USED){1'b0}}, out_item_ff};

endmodule

@@ tb/testbench.sv @@
// testbench for button_debounce_combo_detector_unit: stream driver, result monitor, self-check
// depends on bdcd_pkg and the rtl top level; predicts every result from its own state copy
`timescale 1ns / 1ps

module testbench;
   import bdcd_pkg::*;

   localparam int REQ_W = $bits(req_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = CSR_DEBOUNCE;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   button_debounce_combo_detector_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

   // predictor state
   logic [CFG_BITS-1:0]  set_debounce = DEBOUNCE_RESET;
   logic [CFG_BITS-1:0]  set_combo    = COMBO_RESET;
   logic [CFG_BITS-1:0]  set_pulse    = PULSE_RESET;
   logic [NUM_BTN-1:0]   btn_raw      = '0;
   logic [NUM_BTN-1:0]   btn_stable   = '0;
   logic [TIME_BITS-1:0] btn_change_t [NUM_BTN] = '{default: '0};
   logic                 synced       = 1'b0;
   logic                 blue_wait    = 1'b0;
   logic                 red_wait     = 1'b0;
   logic [TIME_BITS-1:0] blue_wait_t  = '0;
   logic [TIME_BITS-1:0] red_wait_t   = '0;
   logic                 relay_busy   = 1'b0;
   logic [TIME_BITS-1:0] relay_t0     = '0;

   logic [REQ_BITS-1:0]  sample_q [$];
   rsp_item_type         due_events_q [$];
   int                   mismatch_count = 0;
   int                   samples_queued = 0;
   logic [TIME_BITS-1:0] t_ms = '0;
   logic                 req_fire = 1'b0;
   logic                 calm = 1'b0;
   logic                 hold_req = 1'b0;
   logic                 hold_taken = 1'b0;
   int                   hold_left = 0;

   function automatic logic ms_passed(input logic [TIME_BITS-1:0] now,
                                      input logic [TIME_BITS-1:0] since,
                                      input logic [CFG_BITS-1:0]  span);
      logic [TIME_BITS-1:0] gap;
      gap = now - since;
      return gap >= TIME_BITS'(span);
   endfunction

   function automatic rsp_item_type debounce_step(input logic [REQ_BITS-1:0] word);
      req_item_type s;
      rsp_item_type r;
      int           b;
      s = req_item_type'(word[REQ_W-1:0]);
      r = '0;
      if (relay_busy && ms_passed(s.now_ms, relay_t0, set_pulse)) begin
         r.relay_off = 1'b1;
         relay_busy  = 1'b0;
      end
      if (!s.link_online) begin
         synced = 1'b0;
      end else if (!synced) begin
         btn_raw    = s.raw_buttons;
         btn_stable = s.raw_buttons;
         for (b = 0; b < NUM_BTN; b++) btn_change_t[b] = s.now_ms;
         synced = 1'b1;
      end else begin
         for (b = 0; b < NUM_BTN; b++) begin
            if (s.raw_buttons[b] != btn_raw[b]) begin
               btn_raw[b]      = s.raw_buttons[b];
               btn_change_t[b] = s.now_ms;
            end else if (s.raw_buttons[b] != btn_stable[b] &&
                         ms_passed(s.now_ms, btn_change_t[b], set_debounce)) begin
               btn_stable[b] = s.raw_buttons[b];
               if (s.raw_buttons[b]) begin
                  case (b)
                     BTN_BLUE: begin
                        blue_wait   = 1'b1;
                        blue_wait_t = s.now_ms;
                     end
                     BTN_RED: begin
                        red_wait   = 1'b1;
                        red_wait_t = s.now_ms;
                     end
                     default: begin
                        r.yellow_event = 1'b1;
                        r.relay_on     = 1'b1;
                        relay_busy     = 1'b1;
                        relay_t0       = s.now_ms;
                     end
                  endcase
               end
            end
         end
         if (blue_wait && red_wait) begin
            r.combo_event = 1'b1;
            blue_wait     = 1'b0;
            red_wait      = 1'b0;
         end else begin
            if (blue_wait && ms_passed(s.now_ms, blue_wait_t, set_combo)) begin
               r.blue_event = 1'b1;
               blue_wait    = 1'b0;
            end
            if (red_wait && ms_passed(s.now_ms, red_wait_t, set_combo)) begin
               r.red_event = 1'b1;
               red_wait    = 1'b0;
            end
         end
      end
      r.stable_buttons = btn_stable;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [2:0] want,
                                       input logic [2:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // monitor: input transfers feed the predictor, result transfers are checked
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[RSP_W-1:0]);
         if (due_events_q.size() == 0) begin
            mismatch_count++;
            $display("%0t ns unexpected result: expected none actual %h", $time, got);
         end else begin
            want = due_events_q.pop_front();
            check_field("blue_event", 3'(want.blue_event), 3'(got.blue_event));
            check_field("red_event", 3'(want.red_event), 3'(got.red_event));
            check_field("combo_event", 3'(want.combo_event), 3'(got.combo_event));
            check_field("yellow_event", 3'(want.yellow_event), 3'(got.yellow_event));
            check_field("relay_off", 3'(want.relay_off), 3'(got.relay_off));
            check_field("relay_on", 3'(want.relay_on), 3'(got.relay_on));
            check_field("stable_buttons", want.stable_buttons, got.stable_buttons);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         req_fire = 1'b1;
         due_events_q.push_back(debounce_step(req_tdata));
      end else begin
         req_fire = 1'b0;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (sample_q.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
            req_tdata  <= sample_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver with one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= 19;
      end
   end

   task automatic put_sample(input logic online, input logic [2:0] raw,
                             input logic [TIME_BITS-1:0] now);
      req_item_type s;
      s.link_online = online;
      s.raw_buttons = raw;
      s.now_ms      = now;
      sample_q.push_back(REQ_BITS'(s));
      samples_queued++;
   endtask

   task automatic wait_idle();
      while (sample_q.size() != 0 || req_tvalid || due_events_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CFG_BITS-1:0] deb,
                                 input logic [CFG_BITS-1:0] win,
                                 input logic [CFG_BITS-1:0] pls);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(negedge clock);
      csr_index <= CSR_COMBO;
      csr_wdata <= win;
      @(negedge clock);
      csr_index <= CSR_PULSE;
      csr_wdata <= pls;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      set_debounce = deb;
      set_combo    = win;
      set_pulse    = pls;
   endtask

   function automatic int step_span();
      int m;
      m = set_debounce;
      if (set_combo > m) m = set_combo;
      if (set_pulse > m) m = set_pulse;
      return (m >> 2) + 1;
   endfunction

   // hold a button pattern for a while, with some bounce at the start
   task automatic press_run(input logic [2:0] lv, input int samples);
      logic [2:0] raw;
      logic       on;
      int         k;
      for (k = 0; k < samples; k++) begin
         raw = lv;
         if (k < 2 && $urandom_range(0, 99) < 30) raw = lv ^ (3'b001 << $urandom_range(0, 2));
         on = ($urandom_range(0, 99) >= 3);
         t_ms = t_ms + $urandom_range(0, step_span());
         put_sample(on, raw, t_ms);
      end
   endtask

   task automatic random_phase(input int n);
      int start;
      int k;
      int j;
      start = samples_queued;
      while (samples_queued - start < n) begin
         k = $urandom_range(0, 9);
         case (k)
            0, 1: begin
               press_run(3'b001 << $urandom_range(0, 1), $urandom_range(1, 3));
               press_run(3'b011, $urandom_range(6, 12));
               press_run(3'b000, $urandom_range(4, 8));
            end
            2, 3: begin
               press_run(3'b001 << $urandom_range(0, 2), $urandom_range(6, 14));
               press_run(3'b000, $urandom_range(4, 8));
            end
            4: begin
               press_run(3'b100 | 3'($urandom_range(0, 3)), $urandom_range(6, 12));
               press_run(3'b000, $urandom_range(4, 10));
            end
            5: begin
               for (j = 0; j < $urandom_range(1, 4); j++) begin
                  t_ms = $urandom();
                  put_sample(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), t_ms);
               end
            end
            6: begin
               for (j = 0; j < $urandom_range(1, 3); j++) begin
                  t_ms = t_ms + $urandom_range(0, step_span());
                  put_sample(1'b0, 3'($urandom_range(0, 7)), t_ms);
               end
            end
            default: press_run(3'($urandom_range(0, 7)), $urandom_range(3, 10));
         endcase
      end
   endtask

   function automatic logic [CFG_BITS-1:0] pick_setting();
      if ($urandom_range(0, 3) == 0) return CFG_BITS'($urandom_range(0, 65535));
      return CFG_BITS'($urandom_range(0, 300));
   endfunction

   initial begin
      int p;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk through combo, red single, yellow pulse, offline and wrap
      put_sample(1'b0, 3'b111, 32'hFFFF_FFFF);
      put_sample(1'b1, 3'b000, 32'd0);
      put_sample(1'b1, 3'b001, 32'd10);
      put_sample(1'b1, 3'b001, 32'd40);
      put_sample(1'b1, 3'b011, 32'd50);
      put_sample(1'b1, 3'b011, 32'd80);
      put_sample(1'b1, 3'b000, 32'd90);
      put_sample(1'b1, 3'b000, 32'd120);
      put_sample(1'b1, 3'b100, 32'd130);
      put_sample(1'b1, 3'b100, 32'd160);
      put_sample(1'b1, 3'b110, 32'd170);
      put_sample(1'b1, 3'b110, 32'd200);
      put_sample(1'b1, 3'b110, 32'd300);
      put_sample(1'b1, 3'b100, 32'd310);
      put_sample(1'b1, 3'b000, 32'd320);
      put_sample(1'b1, 3'b000, 32'd350);
      put_sample(1'b1, 3'b100, 32'd360);
      put_sample(1'b1, 3'b100, 32'd660);
      put_sample(1'b0, 3'b100, 32'd700);
      put_sample(1'b1, 3'b001, 32'd710);
      put_sample(1'b1, 3'b001, 32'd1200);
      put_sample(1'b1, 3'b000, 32'hFFFF_FFF0);
      put_sample(1'b1, 3'b000, 32'h0000_000E);
      wait_idle();

      write_settings('0, '0, '0);
      random_phase(250);
      wait_idle();

      write_settings('1, '1, '1);
      t_ms = 32'hFFFF_0000;
      random_phase(250);
      wait_idle();

      // long run with no gaps on either side
      write_settings(DEBOUNCE_RESET, COMBO_RESET, PULSE_RESET);
      calm = 1'b1;
      random_phase(400);
      wait_idle();
      calm = 1'b0;

      // receiver backs off while the sender keeps offering
      hold_req = 1'b1;
      random_phase(400);
      wait_idle();

      for (p = 0; p < 3; p++) begin
         write_settings(pick_setting(), pick_setting(), pick_setting());
         t_ms = $urandom();
         random_phase(200);
         wait_idle();
      end

      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && due_events_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
